/* src/fresnel_reflectance_by_angle_core_defines.svh */
// Assertion macros for the Fresnel reflectance core.
// Included by the top level; expects clk and rst in scope.
`ifndef FRESNEL_REFLECTANCE_BY_ANGLE_CORE_DEFINES_SVH
`define FRESNEL_REFLECTANCE_BY_ANGLE_CORE_DEFINES_SVH

// same-cycle implication
`define FRBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/frba_pkg.sv */
// Shared widths, constants and types for the Fresnel reflectance core.
// No dependencies.
package frba_pkg;

  localparam int XY_W   = 34;   // CORDIC x/y, signed Q30 with headroom
  localparam int Z_W    = 27;   // CORDIC residual angle, signed
  localparam int ANG_W  = 25;   // incidence angle, 2^-24 rad
  localparam int SC_W   = 31;   // clamped sin/cos, Q30 in [0, 2^30]
  localparam int ROOT_W = 32;   // square root result bits
  localparam int SREM_W = 34;   // square root remainder
  localparam int RDEN_W = 64;   // ratio numerator/denominator before normalizing
  localparam int NORM_STEPS = 6;
  localparam int QDIV_W = 31;   // normalized denominator width
  localparam int DIV_STEPS  = 31;
  localparam int SQ_W   = 63;   // ratio squared, Q62

  localparam logic [ANG_W-1:0] HALF_PI_ANGLE = 25'd26353589;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [XY_W-1:0] ONE_Q30 = 34'sd1073741824;
  localparam logic [16:0] FULL_REFL = 17'd65536;

  localparam logic [1:0] REG_ANGLE_STEP  = 2'd0;
  localparam logic [1:0] REG_INDEX_OUTER = 2'd1;
  localparam logic [1:0] REG_INDEX_INNER = 2'd2;

  typedef struct packed {
    logic [32:0] a_term;
    logic [48:0] p_term;
    logic        crit;
    logic        zero;
  } sqrt_side_t;

  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] v;
    v = '0;
    case (i)
      0: v = 27'sd13176795;
      1: v = 27'sd7778716;
      2: v = 27'sd4110060;
      3: v = 27'sd2086331;
      4: v = 27'sd1047214;
      5: v = 27'sd524117;
      6: v = 27'sd262123;
      7: v = 27'sd131069;
      default: begin
        if (i <= 24) v = 27'sd1 <<< (24 - i);
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

/* src/frba_cordic_cell.sv */
// One rotation stage of the sin/cos CORDIC chain.
// Depends on frba_pkg.
module frba_cordic_cell import frba_pkg::*; #(
  parameter int STAGE = 0,
  parameter int SW = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [XY_W-1:0] in_x,
  input  logic signed [XY_W-1:0] in_y,
  input  logic signed [Z_W-1:0]  in_z,
  input  logic [SW-1:0]          in_side,
  output logic                   out_valid,
  output logic signed [XY_W-1:0] out_x,
  output logic signed [XY_W-1:0] out_y,
  output logic signed [Z_W-1:0]  out_z,
  output logic [SW-1:0]          out_side
);
  localparam logic signed [Z_W-1:0] ATAN = atan_entry(STAGE);

  logic signed [XY_W-1:0] dx, dy;
  assign dx = in_y >>> STAGE;
  assign dy = in_x >>> STAGE;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      if (in_z >= 0) begin
        out_x <= in_x - dx;
        out_y <= in_y + dy;
        out_z <= in_z - ATAN;
      end else begin
        out_x <= in_x + dx;
        out_y <= in_y - dy;
        out_z <= in_z + ATAN;
      end
    end
  end
endmodule

/* src/frba_sqrt_cell.sv */
// One result bit of the restoring integer square root chain.
// Depends on frba_pkg.
module frba_sqrt_cell import frba_pkg::*; #(
  parameter int PAIR = 0,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       in_rad,
  input  logic [SREM_W-1:0] in_rem,
  input  logic [ROOT_W-1:0] in_root,
  input  logic [SW-1:0]     in_side,
  output logic              out_valid,
  output logic [63:0]       out_rad,
  output logic [SREM_W-1:0] out_rem,
  output logic [ROOT_W-1:0] out_root,
  output logic [SW-1:0]     out_side
);
  localparam int LO = 2 * PAIR;

  logic [SREM_W+1:0] trial, tsub;
  logic              ge;
  assign trial = {in_rem, in_rad[LO+1 -: 2]};
  assign tsub  = {2'b00, in_root, 2'b01};
  assign ge    = trial >= tsub;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rad  <= in_rad;
      out_side <= in_side;
      out_rem  <= ge ? SREM_W'(trial - tsub) : SREM_W'(trial);
      out_root <= {in_root[ROOT_W-2:0], ge};
    end
  end
endmodule

/* src/frba_div_cell.sv */
// One quotient bit of the restoring divider chain.
// Depends on frba_pkg.
module frba_div_cell import frba_pkg::*; #(
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [QDIV_W-1:0] in_rem,
  input  logic [QDIV_W-1:0] in_den,
  input  logic [QDIV_W:0]   in_q,
  input  logic [SW-1:0]     in_side,
  output logic              out_valid,
  output logic [QDIV_W-1:0] out_rem,
  output logic [QDIV_W-1:0] out_den,
  output logic [QDIV_W:0]   out_q,
  output logic [SW-1:0]     out_side
);
  logic [QDIV_W:0] r2;
  logic            ge;
  assign r2 = {in_rem, 1'b0};
  assign ge = r2 >= {1'b0, in_den};

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_den  <= in_den;
      out_side <= in_side;
      out_rem  <= ge ? QDIV_W'(r2 - {1'b0, in_den}) : r2[QDIV_W-1:0];
      out_q    <= {in_q[QDIV_W-1:0], ge};
    end
  end
endmodule

/* src/frba_ratio.sv */
// Squared ratio (num/den)^2 in Q62: normalize, divide bit-serially
// along a chain of cells, square. Depends on frba_pkg, frba_div_cell.
module frba_ratio import frba_pkg::*; #(
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RDEN_W-1:0] num,
  input  logic [RDEN_W-1:0] den,
  input  logic [SW-1:0]     in_side,
  output logic              out_valid,
  output logic [SQ_W-1:0]   sq,
  output logic [SW-1:0]     out_side
);
  // side bit SW marks a zero denominator
  logic              nv   [NORM_STEPS+1];
  logic [RDEN_W-1:0] nnum [NORM_STEPS+1];
  logic [RDEN_W-1:0] nden [NORM_STEPS+1];
  logic [SW:0]       nside[NORM_STEPS+1];

  assign nv[0]    = in_valid;
  assign nnum[0]  = num;
  assign nden[0]  = den;
  assign nside[0] = {den == '0, in_side};

  // greedy shift: largest steps first, until den < 2^31
  // a step of K is taken while a shift of K-1 would still leave den >= 2^31
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int K = 1 << (NORM_STEPS - 1 - j);
    logic big;
    assign big = (nden[j] >> (K - 1)) > RDEN_W'(64'h7FFF_FFFF);
    always_ff @(posedge clk) begin
      if (rst) nv[j+1] <= 1'b0;
      else if (en) nv[j+1] <= nv[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        nside[j+1] <= nside[j];
        nnum[j+1]  <= big ? (nnum[j] >> K) : nnum[j];
        nden[j+1]  <= big ? (nden[j] >> K) : nden[j];
      end
    end
  end

  // integer part of the quotient (0 or 1)
  logic [QDIV_W-1:0] nd, nn;
  logic              qh;
  assign nd = nden[NORM_STEPS][QDIV_W-1:0];
  assign nn = (nnum[NORM_STEPS] > nden[NORM_STEPS]) ? nd
            : nnum[NORM_STEPS][QDIV_W-1:0];
  assign qh = nn >= nd;

  logic              dv   [DIV_STEPS+1];
  logic [QDIV_W-1:0] drem [DIV_STEPS+1];
  logic [QDIV_W-1:0] dden [DIV_STEPS+1];
  logic [QDIV_W:0]   dq   [DIV_STEPS+1];
  logic [SW:0]       dside[DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= nv[NORM_STEPS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dside[0] <= nside[NORM_STEPS];
      dden[0]  <= nd;
      drem[0]  <= qh ? QDIV_W'(nn - nd) : nn;
      dq[0]    <= {{QDIV_W{1'b0}}, qh};
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    frba_div_cell #(.SW(SW + 1)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(dv[j]), .in_rem(drem[j]), .in_den(dden[j]),
      .in_q(dq[j]), .in_side(dside[j]),
      .out_valid(dv[j+1]), .out_rem(drem[j+1]), .out_den(dden[j+1]),
      .out_q(dq[j+1]), .out_side(dside[j+1])
    );
  end

  logic [63:0] r_sq;
  assign r_sq = {32'b0, dq[DIV_STEPS]} * {32'b0, dq[DIV_STEPS]};

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv[DIV_STEPS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= dside[DIV_STEPS][SW-1:0];
      sq <= dside[DIV_STEPS][SW] ? (SQ_W'(1) << 62) : r_sq[SQ_W-1:0];
    end
  end
endmodule

/* src/fresnel_reflectance_by_angle_core.sv */
// Fresnel reflectance core, top level: config registers, pipeline
// from angle index to reflectance, output register with skid stage.
// Depends on frba_pkg, frba_cordic_cell, frba_sqrt_cell, frba_ratio and the defines header.

// Unpolarized Fresnel reflectance from tissue into water, one request per
// angle index. The core is a fully pipelined chain of cells and takes a new
// request every clock cycle while not stalled. Its stages: 2 input stages,
// the CORDIC chain, 5 arithmetic stages, 32 square-root cells, 39 stages
// per ratio unit of which 31 are divider cells, and the output register.
// The two ratio units run side by side. Results come out in request order.
// An output register plus one skid entry decouple the output: input stalls
// only when both hold a request, and the whole chain holds then. Config
// writes are always accepted and must only be issued while the core is
// empty. Reflectance is Q1.16 with 65536 meaning full reflection;
// total_reflection flags incidence beyond the critical angle.
module fresnel_reflectance_by_angle_core import frba_pkg::*; #(
  parameter int ANGLE_STEPS   = 1024,
  parameter int CORDIC_STAGES = 20
) (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  angle_index,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] reflectance,
  output logic        total_reflection
);
`include "fresnel_reflectance_by_angle_core_defines.svh"

  localparam int N = CORDIC_STAGES;
  localparam logic [16:0] STEPS17  = 17'(ANGLE_STEPS);
  localparam logic [9:0]  IDX_LAST = 10'(ANGLE_STEPS - 1);

  // ---------------- config registers ----------------
  logic [23:0] angle_step;
  logic [15:0] index_outer, index_inner;
  logic [31:0] outer_sq;   // index_outer^2, Q4.28

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_step  <= 24'd25736;
      index_outer <= 16'd21791;
      index_inner <= 16'd22446;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ANGLE_STEP:  angle_step  <= cfg_data;
        REG_INDEX_OUTER: index_outer <= cfg_data[15:0];
        REG_INDEX_INNER: index_inner <= cfg_data[15:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    outer_sq <= {16'b0, index_outer} * {16'b0, index_outer};
  end

  // ---------------- flow control ----------------
  // whole chain advances unless the skid entry is occupied
  logic en;
  logic skid_valid;
  assign en       = !skid_valid;
  assign in_ready = en;

  // ---------------- S0/S1: index clamp, angle ----------------
  logic       v0;
  logic [9:0] idx0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) idx0 <= ({7'b0, angle_index} >= STEPS17) ? IDX_LAST : angle_index;
  end

  logic [33:0]      prod;
  logic             v1, zero1;
  logic [ANG_W-1:0] alpha1;
  assign prod = {24'b0, idx0} * {10'b0, angle_step};
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      alpha1 <= (prod > 34'(HALF_PI_ANGLE)) ? HALF_PI_ANGLE : prod[ANG_W-1:0];
      zero1  <= prod == '0;
    end
  end

  // ---------------- CORDIC chain ----------------
  logic                   cv [N+1];
  logic signed [XY_W-1:0] cx [N+1];
  logic signed [XY_W-1:0] cy [N+1];
  logic signed [Z_W-1:0]  cz [N+1];
  logic [0:0]             cs [N+1];

  assign cv[0] = v1;
  assign cx[0] = CORDIC_GAIN;
  assign cy[0] = '0;
  assign cz[0] = $signed({2'b00, alpha1});
  assign cs[0] = zero1;

  for (genvar j = 0; j < N; j++) begin : g_cordic
    frba_cordic_cell #(.STAGE(j), .SW(1)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(cv[j]), .in_x(cx[j]), .in_y(cy[j]), .in_z(cz[j]), .in_side(cs[j]),
      .out_valid(cv[j+1]), .out_x(cx[j+1]), .out_y(cy[j+1]), .out_z(cz[j+1]),
      .out_side(cs[j+1])
    );
  end

  // ---------------- S2: clamp sin/cos to [0, 1] ----------------
  logic            v2, zero2;
  logic [SC_W-1:0] s2, c2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= cv[N];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      zero2 <= cs[N][0];
      s2 <= (cy[N] < 0) ? '0 : (cy[N] > ONE_Q30) ? SC_W'(ONE_Q30) : cy[N][SC_W-1:0];
      c2 <= (cx[N] < 0) ? '0 : (cx[N] > ONE_Q30) ? SC_W'(ONE_Q30) : cx[N][SC_W-1:0];
    end
  end

  // ---------------- S3: index products ----------------
  logic        v3, zero3;
  logic [46:0] u3;       // n1*sin, Q44
  logic [32:0] a3;       // n1*cos, Q30
  logic [48:0] p3;       // n2^2*cos, Q44
  logic [46:0] n1c;
  logic [62:0] n2c;
  assign n1c = {16'b0, c2} * {31'b0, index_inner};
  assign n2c = {32'b0, c2} * {31'b0, outer_sq};
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      zero3 <= zero2;
      u3 <= {16'b0, s2} * {31'b0, index_inner};
      a3 <= n1c[46:14];
      p3 <= n2c[62:14];
    end
  end

  // ---------------- S4: critical test, (u>>14)^2 ----------------
  logic        v4, zero4, crit4;
  logic [63:0] usq4;
  logic [32:0] a4;
  logic [48:0] p4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      zero4 <= zero3;
      crit4 <= u3 > {1'b0, index_outer, 30'b0};
      usq4  <= {32'b0, u3[45:14]} * {32'b0, u3[45:14]};
      a4 <= a3;
      p4 <= p3;
    end
  end

  // ---------------- S5: radicand ----------------
  logic        v5;
  logic [63:0] rad5;
  sqrt_side_t  side5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rad5  <= {outer_sq, 32'b0} - usq4;
      side5 <= '{a_term: a4, p_term: p4, crit: crit4, zero: zero4};
    end
  end

  // ---------------- square root chain: n2*cos(beta), Q30 ----------------
  localparam int SSW = $bits(sqrt_side_t);
  logic              sv   [ROOT_W+1];
  logic [63:0]       srad [ROOT_W+1];
  logic [SREM_W-1:0] srem [ROOT_W+1];
  logic [ROOT_W-1:0] sroot[ROOT_W+1];
  logic [SSW-1:0]    sside[ROOT_W+1];

  assign sv[0]    = v5;
  assign srad[0]  = rad5;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sside[0] = side5;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    frba_sqrt_cell #(.PAIR(ROOT_W - 1 - j), .SW(SSW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(sv[j]), .in_rad(srad[j]), .in_rem(srem[j]), .in_root(sroot[j]),
      .in_side(sside[j]),
      .out_valid(sv[j+1]), .out_rad(srad[j+1]), .out_rem(srem[j+1]),
      .out_root(sroot[j+1]), .out_side(sside[j+1])
    );
  end

  // ---------------- S6: n1*W ----------------
  sqrt_side_t  sfin, side6;
  logic        v6;
  logic [31:0] w6;
  logic [47:0] q6;
  assign sfin = sside[ROOT_W];
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= sv[ROOT_W];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side6 <= sfin;
      w6 <= sroot[ROOT_W];
      q6 <= {16'b0, sroot[ROOT_W]} * {32'b0, index_inner};
    end
  end

  // ratio operands; at zero angle rs becomes (n1-n2)/(n1+n2)
  logic [RDEN_W-1:0] num1, den1, num2, den2;
  always_comb begin
    if (side6.zero) begin
      num1 = (index_inner >= index_outer) ? RDEN_W'(index_inner - index_outer)
                                          : RDEN_W'(index_outer - index_inner);
      den1 = RDEN_W'({1'b0, index_inner} + {1'b0, index_outer});
    end else begin
      num1 = (side6.a_term >= {1'b0, w6}) ? RDEN_W'(side6.a_term - {1'b0, w6})
                                          : RDEN_W'({1'b0, w6} - side6.a_term);
      den1 = RDEN_W'({1'b0, side6.a_term} + {2'b0, w6});
    end
    num2 = (side6.p_term >= {1'b0, q6}) ? RDEN_W'(side6.p_term - {1'b0, q6})
                                        : RDEN_W'({1'b0, q6} - side6.p_term);
    den2 = RDEN_W'({1'b0, side6.p_term} + {2'b0, q6});
  end

  // ---------------- ratio units (rs, rp) ----------------
  logic            rv1, rv2;
  logic [SQ_W-1:0] sq1, sq2;
  logic [0:0]      crit_r, zero_r;

  frba_ratio #(.SW(1)) u_ratio_s (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v6), .num(num1), .den(den1), .in_side(side6.crit),
    .out_valid(rv1), .sq(sq1), .out_side(crit_r)
  );

  frba_ratio #(.SW(1)) u_ratio_p (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v6), .num(num2), .den(den2), .in_side(side6.zero),
    .out_valid(rv2), .sq(sq2), .out_side(zero_r)
  );

  // ---------------- final rounding ----------------
  logic [64:0] sum_all, sum_zero;
  logic [17:0] r_norm;
  logic [18:0] r_zero;
  logic [16:0] refl_f;
  logic        flag_f;

  assign sum_all  = {2'b0, sq1} + {2'b0, sq2} + (65'd1 << 46);
  assign sum_zero = {2'b0, sq1} + (65'd1 << 45);
  assign r_norm   = sum_all[64:47];
  assign r_zero   = sum_zero[64:46];

  always_comb begin
    flag_f = 1'b0;
    priority if (zero_r[0]) begin
      refl_f = (r_zero > 19'(FULL_REFL)) ? FULL_REFL : r_zero[16:0];
    end else if (crit_r[0]) begin
      refl_f = FULL_REFL;
      flag_f = 1'b1;
    end else begin
      refl_f = (r_norm > 18'(FULL_REFL)) ? FULL_REFL : r_norm[16:0];
    end
  end

  // ---------------- output register + skid ----------------
  logic [16:0] skid_refl;
  logic        skid_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= rv1;
      end
    end else if (rv1 && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        reflectance      <= skid_refl;
        total_reflection <= skid_flag;
      end else begin
        reflectance      <= refl_f;
        total_reflection <= flag_f;
      end
    end else if (rv1 && en) begin
      skid_refl <= refl_f;
      skid_flag <= flag_f;
    end
  end

  // ---------------- checks ----------------
  `FRBA_ASSERT_NOW(a_skid_needs_out, skid_valid, out_valid, "skid full with output empty")
  `FRBA_ASSERT_NOW(a_ratio_aligned, 1'b1, rv1 == rv2, "ratio units out of step")
  `FRBA_ASSERT_NOW(a_tir_full, out_valid && total_reflection, reflectance == FULL_REFL, "flag without full reflectance")
  `FRBA_ASSERT_NEXT(a_skid_drains, skid_valid && out_ready, !skid_valid, "skid did not drain")

endmodule
